FILE: design/kpve_pkg.sv
// Shared types and constants of the position and velocity estimator.
package kpve_pkg;

    localparam int SampleW = 16;
    localparam int WordW = 32;
    localparam int QW = 24;
    localparam int PeriodW = 10;
    localparam int CntW = 3;

    localparam logic signed [16:0] AdcOffset = 17'sd1833;
    localparam logic [CntW-1:0] AdcDecim = 3'd5;
    localparam logic [CntW-1:0] EncDecim = 3'd2;
    localparam logic [63:0] HalfQ30 = 64'd536870912;
    localparam logic [33:0] OneQ30 = 34'd1073741824;
    localparam logic [6:0] DivSteps = 7'd64;
    localparam logic [6:0] MulSteps = 7'd34;

    // Register indexes of the configuration port.
    localparam logic [1:0] RegSourceMode = 2'd0;
    localparam logic [1:0] RegControlPeriod = 2'd1;
    localparam logic [1:0] RegQPosition = 2'd2;
    localparam logic [1:0] RegQVelocity = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_KSETUP,
        OP_RUN,
        OP_KMUL1,
        OP_KMUL2,
        OP_KEND,
        OP_DECIM,
        OP_VZ,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic vel;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic hit;
        logic src_mode;
        logic out_free;
    } t_stat;

endpackage

FILE: design/kpve_ctrl.sv
// Sequencer that steps the datapath through the filter updates of one word.
module kpve_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  kpve_pkg::t_stat i_stat,
    output kpve_pkg::t_cmd  o_cmd
);
    import kpve_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SETUP = 12'b000000000010,
        S_DIV   = 12'b000000000100,
        S_MUL1  = 12'b000000001000,
        S_RUN1  = 12'b000000010000,
        S_MUL2  = 12'b000000100000,
        S_RUN2  = 12'b000001000000,
        S_KEND  = 12'b000010000000,
        S_DECIM = 12'b000100000000,
        S_VDIV  = 12'b001000000000,
        S_VZ    = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_vel, n_vel;

    always_comb begin
        n_state = r_state;
        n_vel = r_vel;
        o_cmd.op = OP_NONE;
        o_cmd.vel = r_vel;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_vel = 1'b0;
                    n_state = i_stat.src_mode ? S_DECIM : S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.op = OP_KSETUP;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_RUN;
                if (i_stat.done) n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = OP_KMUL1;
                n_state = S_RUN1;
            end
            S_RUN1: begin
                o_cmd.op = OP_RUN;
                if (i_stat.done) n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = OP_KMUL2;
                n_state = S_RUN2;
            end
            S_RUN2: begin
                o_cmd.op = OP_RUN;
                if (i_stat.done) n_state = S_KEND;
            end
            S_KEND: begin
                o_cmd.op = OP_KEND;
                n_state = r_vel ? S_OUT : S_DECIM;
            end
            S_DECIM: begin
                o_cmd.op = OP_DECIM;
                n_state = i_stat.hit ? S_VDIV : S_OUT;
            end
            S_VDIV: begin
                o_cmd.op = OP_RUN;
                if (i_stat.done) n_state = S_VZ;
            end
            S_VZ: begin
                o_cmd.op = OP_VZ;
                n_vel = 1'b1;
                n_state = S_SETUP;
            end
            S_OUT: begin
                o_cmd.op = OP_OUT;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vel <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vel <= n_vel;
        end
    end

endmodule

FILE: design/kpve_dp.sv
// Datapath: filter state, configuration, a bit-serial multiply/divide unit and the output word.
module kpve_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kpve_pkg::t_cmd                   i_cmd,
    output kpve_pkg::t_stat                  o_stat,
    input  logic [kpve_pkg::SampleW-1:0]     i_sample,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [kpve_pkg::QW-1:0]          i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [kpve_pkg::WordW-1:0]       o_position,
    output logic [kpve_pkg::WordW-1:0]       o_velocity,
    output logic                             o_updated
);
    import kpve_pkg::*;

    // Configuration
    logic               r_src_mode;
    logic [PeriodW-1:0] r_period;
    logic [QW-1:0]      r_qp, r_qv;

    // Filter state
    logic [WordW-1:0] r_pos_est, r_pos_var, r_vel_est, r_vel_var, r_prior;
    logic [CntW-1:0]  r_cnt;

    // Working registers
    logic [SampleW-1:0] r_sample;
    logic               r_mode;
    logic [WordW-1:0]   r_z, r_x, r_p, r_position;
    logic [QW-1:0]      r_q;
    logic [32:0]        r_pmid;
    logic [29:0]        r_k;
    logic               r_neg, r_upd;

    // Serial unit
    logic [6:0]  r_scnt;
    logic        r_div;
    logic [63:0] r_quo, r_acc, r_mc;
    logic [34:0] r_rem;
    logic [33:0] r_dvs, r_mp;

    // Output word
    logic             r_out_valid, r_out_upd;
    logic [WordW-1:0] r_out_pos, r_out_vel;

    logic             out_free;
    logic [CntW-1:0]  cnt1;
    logic             hit;
    logic [WordW-1:0] position;
    logic [32:0]      pdiff;
    logic [40:0]      dx, d100, mag;
    logic [16:0]      zs;
    logic [WordW-1:0] z_adc;
    logic [32:0]      pmid;
    logic [32:0]      zdiff;
    logic [63:0]      rsum, psum;
    logic [34:0]      nx;
    logic [WordW-1:0] nx_sat, v_sat;
    logic [34:0]      rem_sh;
    logic [33:0]      per;

    assign out_free = !r_out_valid || i_out_ready;
    assign cnt1 = r_cnt + 3'd1;
    assign hit = cnt1 >= (r_mode ? EncDecim : AdcDecim);
    assign position = r_mode ? {r_sample, 16'h0000} : r_pos_est;
    assign pdiff = {position[31], position} - {r_prior[31], r_prior};
    assign dx = {{8{pdiff[32]}}, pdiff};
    assign d100 = (dx << 6) + (dx << 5) + (dx << 2);
    assign mag = d100[40] ? (41'd0 - d100) : d100;
    assign per = (r_period == '0) ? 34'd1 : {24'd0, r_period};

    assign zs = {i_sample[15], i_sample} - AdcOffset;
    // Only the low end can leave the 32-bit range after the offset.
    assign z_adc = (zs[16] && !zs[15]) ? 32'h8000_0000 : {zs[15:0], 16'h0000};

    assign pmid = {1'b0, r_p} + {3'd0, r_q, 6'd0};
    assign zdiff = {r_z[31], r_z} - {r_x[31], r_x};
    assign rsum = r_acc + HalfQ30;
    assign psum = r_acc + HalfQ30;
    assign nx = {{3{r_x[31]}}, r_x} + {rsum[63], rsum[63:30]};
    assign nx_sat = (nx[34:31] == 4'b0000 || nx[34:31] == 4'b1111) ? nx[31:0] :
                    (nx[34] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    always_comb begin
        if (!r_neg) begin
            v_sat = (r_quo > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : r_quo[31:0];
        end else begin
            v_sat = (r_quo > 64'h0000_0000_8000_0000) ? 32'h8000_0000
                                                      : (32'd0 - r_quo[31:0]);
        end
    end

    assign rem_sh = {r_rem[33:0], r_quo[63]};

    assign o_stat.done = (r_scnt == '0);
    assign o_stat.hit = hit;
    assign o_stat.src_mode = r_src_mode;
    assign o_stat.out_free = out_free;

    // Configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_mode <= 1'b1;
            r_period <= 10'd1;
            r_qp <= 24'd167772;
            r_qv <= 24'd16777;
            r_pos_est <= '0;
            r_pos_var <= '0;
            r_vel_est <= '0;
            r_vel_var <= '0;
            r_prior <= '0;
            r_cnt <= '0;
            r_scnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegSourceMode:    r_src_mode <= i_cfg_data[0];
                    RegControlPeriod: r_period <= i_cfg_data[PeriodW-1:0];
                    RegQPosition:     r_qp <= i_cfg_data;
                    RegQVelocity:     r_qv <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_KSETUP: r_scnt <= DivSteps;
                OP_KMUL1, OP_KMUL2: r_scnt <= MulSteps;
                OP_RUN: if (r_scnt != '0) r_scnt <= r_scnt - 7'd1;
                OP_KEND: begin
                    if (i_cmd.vel) begin
                        r_vel_est <= r_x;
                        r_vel_var <= psum[61:30];
                    end else begin
                        r_pos_est <= r_x;
                        r_pos_var <= psum[61:30];
                    end
                end
                OP_DECIM: begin
                    if (hit) begin
                        r_cnt <= '0;
                        r_prior <= position;
                        r_scnt <= DivSteps;
                    end else begin
                        r_cnt <= cnt1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_sample <= i_sample;
                r_mode <= r_src_mode;
                r_z <= z_adc;
                r_x <= r_pos_est;
                r_p <= r_pos_var;
                r_q <= r_qp;
                r_upd <= 1'b0;
            end
            OP_KSETUP: begin
                r_pmid <= pmid;
                r_quo <= {1'b0, pmid, 30'd0};
                r_dvs <= {1'b0, pmid} + OneQ30;
                r_rem <= '0;
                r_div <= 1'b1;
            end
            OP_RUN: begin
                if (r_scnt != '0) begin
                    if (r_div) begin
                        if (rem_sh >= {1'b0, r_dvs}) begin
                            r_rem <= rem_sh - {1'b0, r_dvs};
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                    end else begin
                        if (r_mp[0]) r_acc <= r_acc + r_mc;
                        r_mc <= {r_mc[62:0], 1'b0};
                        r_mp <= {1'b0, r_mp[33:1]};
                    end
                end
            end
            OP_KMUL1: begin
                r_k <= r_quo[29:0];
                r_mc <= {{31{zdiff[32]}}, zdiff};
                r_mp <= {4'd0, r_quo[29:0]};
                r_acc <= '0;
                r_div <= 1'b0;
            end
            OP_KMUL2: begin
                r_x <= nx_sat;
                r_mc <= {31'd0, r_pmid};
                r_mp <= OneQ30 - {4'd0, r_k};
                r_acc <= '0;
                r_div <= 1'b0;
            end
            OP_DECIM: begin
                r_position <= position;
                if (hit) begin
                    r_upd <= 1'b1;
                    r_neg <= d100[40];
                    r_quo <= {23'd0, mag};
                    r_dvs <= per;
                    r_rem <= '0;
                    r_div <= 1'b1;
                end
            end
            OP_VZ: begin
                r_z <= v_sat;
                r_x <= r_vel_est;
                r_p <= r_vel_var;
                r_q <= r_qv;
            end
            OP_OUT: begin
                if (out_free) begin
                    r_out_pos <= r_position;
                    r_out_vel <= r_vel_est;
                    r_out_upd <= r_upd;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_position = r_out_pos;
    assign o_velocity = r_out_vel;
    assign o_updated = r_out_upd;

endmodule

FILE: design/kalman_position_velocity_estimator.sv
// Top level of the position and velocity estimator.
// Each input word is one position sample; each output word carries the position (the filter
// estimate for ADC samples, the raw sample for encoder samples), the filtered velocity and a
// flag that marks a velocity update. Words are handled one at a time by a bit-serial
// multiply/divide unit. One scalar filter update runs a 64-step division for the gain and two
// 34-step multiplications; the velocity division is a 64-step division. An ADC sample runs
// the position update, an encoder sample none; when the decimation count is reached, the
// velocity division and the velocity update follow. A finished word waits in the output
// register while the next sample is taken; while that register is still full the sequencer
// holds the next word. Configuration writes are always accepted.
module kalman_position_velocity_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] position, [63:32] velocity
    output logic [0:0]  m_axis_tuser,   // [0] velocity_updated
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import kpve_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [WordW-1:0] position, velocity;
    logic updated;

    assign o_cfg_ready = 1'b1;

    kpve_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kpve_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_position  (position),
        .o_velocity  (velocity),
        .o_updated   (updated)
    );

    assign m_axis_tdata = {velocity, position};
    assign m_axis_tuser = updated;

endmodule
